// ===== hdl/stbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Spike train burst detector package
// Shared types, constants and saturating helpers for the detector blocks.
// ----------------------------------------------------------------------------
package stbd_pkg;

  localparam int unsigned WinW   = 20;
  localparam int unsigned CntW   = 32;
  localparam int unsigned TotW   = 48;
  localparam int unsigned QDepth = 2;

  // Per-train statistics handed from the front to the back.
  typedef struct packed {
    logic [CntW-1:0] burst_count;
    logic [CntW-1:0] burst_time;
  } train_rec_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [CntW-1:0] sat_add32(input logic [CntW-1:0] a,
                                                input logic [CntW-1:0] b);
    logic [CntW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CntW] ? {CntW{1'b1}} : s[CntW-1:0];
  endfunction

  function automatic logic [TotW-1:0] sat_add48(input logic [TotW-1:0] a,
                                                input logic [CntW-1:0] b);
    logic [TotW:0] s;
    s = {1'b0, a} + {{(TotW-CntW+1){1'b0}}, b};
    return s[TotW] ? {TotW{1'b1}} : s[TotW-1:0];
  endfunction

endpackage

// ===== hdl/stbd_front.sv =====
// ----------------------------------------------------------------------------
// Burst detector front end
// Tracks burst state per spike and emits one record at the end of a train.
// ----------------------------------------------------------------------------
module stbd_front #(
  parameter int unsigned DEFAULT_WINDOW_US = 12000,
  parameter int unsigned TIME_BITS         = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [stbd_pkg::WinW-1:0] cfg_wdata_i,
  input  logic                    spike_valid_i,
  output logic                    spike_ready_o,
  input  logic [31:0]             spike_time_i,
  input  logic                    spike_last_i,
  input  stbd_pkg::q_status_t     q_status_i,
  output logic                    rec_push_o,
  output stbd_pkg::train_rec_t    rec_o
);

  localparam int unsigned TW = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam logic [stbd_pkg::WinW-1:0] DefWin = stbd_pkg::WinW'(DEFAULT_WINDOW_US);

  logic [stbd_pkg::WinW-1:0] win_cfg_q;
  logic [stbd_pkg::WinW-1:0] win;

  logic          in_burst_q, in_burst_d;
  logic [1:0]    held_q, held_d;
  logic [TW-1:0] older_q, older_d;
  logic [TW-1:0] newer_q, newer_d;
  logic [TW-1:0] start_q, start_d;
  logic [stbd_pkg::CntW-1:0] tcount_q, tcount_d;
  logic [stbd_pkg::CntW-1:0] ttime_q, ttime_d;

  logic [TW-1:0] t;
  logic [TW-1:0] gap_nt, gap_ot, dur_sn, dur_st, dur;
  logic          ok_nt, ok_ot, add_dur, accept;

  function automatic logic [TW-1:0] span(input logic [TW-1:0] from,
                                         input logic [TW-1:0] to);
    return (to >= from) ? (to - from) : '0;
  endfunction

  assign t      = spike_time_i[TW-1:0];
  assign win    = (win_cfg_q != '0) ? win_cfg_q : DefWin;
  assign gap_nt = span(newer_q, t);
  assign gap_ot = span(older_q, t);
  assign dur_sn = span(start_q, newer_q);
  assign dur_st = span(start_q, t);
  assign ok_nt  = 32'(gap_nt) <= 32'(win);
  assign ok_ot  = 32'(gap_ot) <= 32'(win);

  assign spike_ready_o = ~q_status_i.full;
  assign accept        = spike_valid_i & spike_ready_o;

  always_comb begin
    in_burst_d = in_burst_q;
    held_d     = held_q;
    older_d    = older_q;
    newer_d    = newer_q;
    start_d    = start_q;
    tcount_d   = tcount_q;
    add_dur    = 1'b0;
    dur        = '0;
    if (in_burst_q) begin
      if (ok_nt) begin
        newer_d = t;
        // A burst still running at the train end closes on this spike.
        add_dur = spike_last_i;
        dur     = dur_st;
      end else begin
        add_dur    = 1'b1;
        dur        = dur_sn;
        in_burst_d = 1'b0;
        older_d    = t;
        held_d     = 2'd1;
      end
    end else begin
      unique case (held_q)
        2'd0: begin
          older_d = t;
          held_d  = 2'd1;
        end
        2'd1: begin
          newer_d = t;
          held_d  = 2'd2;
        end
        default: begin
          if (ok_ot) begin
            tcount_d   = stbd_pkg::sat_add32(tcount_q, 32'd1);
            start_d    = older_q;
            newer_d    = t;
            in_burst_d = 1'b1;
            held_d     = 2'd0;
            add_dur    = spike_last_i;
            dur        = gap_ot;
          end else begin
            older_d = newer_q;
            newer_d = t;
          end
        end
      endcase
    end
    ttime_d = add_dur ? stbd_pkg::sat_add32(ttime_q, 32'(dur)) : ttime_q;
  end

  assign rec_push_o        = accept & spike_last_i;
  assign rec_o.burst_count = tcount_d;
  assign rec_o.burst_time  = ttime_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q  <= '0;
      in_burst_q <= 1'b0;
      held_q     <= '0;
      older_q    <= '0;
      newer_q    <= '0;
      start_q    <= '0;
      tcount_q   <= '0;
      ttime_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        win_cfg_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (spike_last_i) begin
          in_burst_q <= 1'b0;
          held_q     <= '0;
          older_q    <= '0;
          newer_q    <= '0;
          start_q    <= '0;
          tcount_q   <= '0;
          ttime_q    <= '0;
        end else begin
          in_burst_q <= in_burst_d;
          held_q     <= held_d;
          older_q    <= older_d;
          newer_q    <= newer_d;
          start_q    <= start_d;
          tcount_q   <= tcount_d;
          ttime_q    <= ttime_d;
        end
      end
    end
  end

endmodule

// ===== hdl/stbd_queue.sv =====
// ----------------------------------------------------------------------------
// Burst detector record queue
// Small first-in first-out buffer of train records between front and back.
// ----------------------------------------------------------------------------
module stbd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  stbd_pkg::train_rec_t push_data_i,
  input  logic                 pop_i,
  output stbd_pkg::train_rec_t pop_data_o,
  output stbd_pkg::q_status_t  status_o
);

  localparam int unsigned PtrW = $clog2(stbd_pkg::QDepth);

  stbd_pkg::train_rec_t mem_q [stbd_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   fill_q;

  assign status_o.full  = (fill_q == (PtrW+1)'(stbd_pkg::QDepth));
  assign status_o.empty = (fill_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(stbd_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(stbd_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/stbd_back.sv =====
// ----------------------------------------------------------------------------
// Burst detector back end
// Folds train records into saturating totals and holds the result register.
// ----------------------------------------------------------------------------
module stbd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  stbd_pkg::q_status_t         q_status_i,
  input  stbd_pkg::train_rec_t        rec_i,
  output logic                        pop_o,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [stbd_pkg::CntW-1:0]   neuron_burst_count_o,
  output logic                        neuron_bursted_o,
  output logic [stbd_pkg::CntW-1:0]   neuron_burst_time_us_o,
  output logic [stbd_pkg::TotW-1:0]   total_burst_events_o,
  output logic [stbd_pkg::CntW-1:0]   bursting_neuron_total_o,
  output logic [stbd_pkg::TotW-1:0]   total_burst_time_us_o
);

  logic                      valid_q;
  logic [stbd_pkg::CntW-1:0] count_q, time_q, neurons_q;
  logic                      bursted_q, bursted;
  logic [stbd_pkg::TotW-1:0] events_q, ttot_q;

  assign bursted = (rec_i.burst_count != '0);
  assign pop_o   = ~q_status_i.empty & (~valid_q | res_ready_i);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      count_q   <= rec_i.burst_count;
      time_q    <= rec_i.burst_time;
      bursted_q <= bursted;
    end
  end

  // Running totals double as the output payload of the total fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      events_q  <= '0;
      neurons_q <= '0;
      ttot_q    <= '0;
    end else begin
      if (pop_o) begin
        valid_q   <= 1'b1;
        events_q  <= stbd_pkg::sat_add48(events_q, rec_i.burst_count);
        neurons_q <= stbd_pkg::sat_add32(neurons_q, {31'd0, bursted});
        ttot_q    <= stbd_pkg::sat_add48(ttot_q, rec_i.burst_time);
      end else if (res_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o             = valid_q;
  assign neuron_burst_count_o    = count_q;
  assign neuron_bursted_o        = bursted_q;
  assign neuron_burst_time_us_o  = time_q;
  assign total_burst_events_o    = events_q;
  assign bursting_neuron_total_o = neurons_q;
  assign total_burst_time_us_o   = ttot_q;

endmodule

// ===== hdl/spike_train_burst_detector_core.sv =====
// Path: a train's final spike writes its record into the queue; the back moves it
//   to the output register once free or draining. Throughput: one spike per cycle
//   while the queue is not full; the front's subtract-compare-add path sets it.
// Results leave at up to one per cycle; a two-entry record queue absorbs stalls.
// Reset (rst_ni low, asynchronous) clears burst state, the window register
//   (default window in force) and all running totals.
// ----------------------------------------------------------------------------
// Spike train burst detector core
// Max-interval burst detection on spike timestamps with per-train statistics
// and saturating running totals across trains.
// ----------------------------------------------------------------------------
module spike_train_burst_detector_core #(
  parameter int unsigned DEFAULT_WINDOW_US = 12000,
  parameter int unsigned TIME_BITS         = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Window register: zero selects the default window.
  input  logic         cfg_we_i,
  input  logic [19:0]  cfg_wdata_i,
  // Spike input stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // [31:0] spike_time
  input  logic         s_axis_tlast,   // last_of_train
  // Result stream, one transfer per train.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [199:0] m_axis_tdata    // [31:0] neuron_burst_count,
                                       // [32] neuron_bursted,
                                       // [64:33] neuron_burst_time_us,
                                       // [112:65] total_burst_events,
                                       // [144:113] bursting_neuron_total,
                                       // [192:145] total_burst_time_us,
                                       // [199:193] zero
);

  // The front runs the burst search on every spike transfer and, on the final
  // spike of a train, pushes the closed train statistics into the queue. It
  // only stalls when the queue is full, so spikes keep flowing while a result
  // waits at the output.
  stbd_pkg::q_status_t  q_status;
  stbd_pkg::train_rec_t push_rec, pop_rec;
  logic                 push, pop;

  logic [31:0] neuron_burst_count, neuron_burst_time_us, bursting_neuron_total;
  logic        neuron_bursted;
  logic [47:0] total_burst_events, total_burst_time_us;

  stbd_front #(
    .DEFAULT_WINDOW_US(DEFAULT_WINDOW_US),
    .TIME_BITS        (TIME_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .spike_valid_i(s_axis_tvalid),
    .spike_ready_o(s_axis_tready),
    .spike_time_i (s_axis_tdata),
    .spike_last_i (s_axis_tlast),
    .q_status_i   (q_status),
    .rec_push_o   (push),
    .rec_o        (push_rec)
  );

  stbd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_rec),
    .pop_i      (pop),
    .pop_data_o (pop_rec),
    .status_o   (q_status)
  );

  // The back takes a record whenever its output register is free or being
  // drained, and updates the saturating totals in the same edge.
  stbd_back u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .q_status_i             (q_status),
    .rec_i                  (pop_rec),
    .pop_o                  (pop),
    .res_valid_o            (m_axis_tvalid),
    .res_ready_i            (m_axis_tready),
    .neuron_burst_count_o   (neuron_burst_count),
    .neuron_bursted_o       (neuron_bursted),
    .neuron_burst_time_us_o (neuron_burst_time_us),
    .total_burst_events_o   (total_burst_events),
    .bursting_neuron_total_o(bursting_neuron_total),
    .total_burst_time_us_o  (total_burst_time_us)
  );

  assign m_axis_tdata = {7'd0, total_burst_time_us, bursting_neuron_total,
                         total_burst_events, neuron_burst_time_us,
                         neuron_bursted, neuron_burst_count};

endmodule

// ===== hdl/stbd_checker.sv =====
// ----------------------------------------------------------------------------
// Burst detector port checker
// Concurrent checks on the result stream of the detector core.
// ----------------------------------------------------------------------------
module stbd_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [199:0] m_axis_tdata
);

  // A stalled result stays offered with the same contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // The bursted flag agrees with the train's burst count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[32] == (m_axis_tdata[31:0] != 32'd0)))
    else $error("bursted flag disagrees with burst count");

  // Running totals include the train being reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({16'd0, m_axis_tdata[31:0]} <= m_axis_tdata[112:65]) &&
                      ({16'd0, m_axis_tdata[64:33]} <= m_axis_tdata[192:145]) &&
                      ({31'd0, m_axis_tdata[32]} <= m_axis_tdata[144:113]))
    else $error("running total below the reported train");

  // The bursting-train count never decreases from one result to the next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready ##1 m_axis_tvalid |->
      m_axis_tdata[144:113] >= $past(m_axis_tdata[144:113]))
    else $error("bursting train total went backward");

endmodule

bind spike_train_burst_detector_core stbd_checker u_stbd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
